FILE: rtl/keyframe_linear_interpolator_assert.svh
// Assertion macros shared by the keyframe interpolator RTL.
// No dependencies; simulation-only bodies, empty under SYNTHESIS.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define KLI_ASSERT(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kli check failed");
`define KLI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kli check failed");
`define KLI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kli check failed");
`else
`define KLI_ASSERT(name, cond)
`define KLI_ASSERT_IMP(name, ante, cons)
`define KLI_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: rtl/kli_pkg.sv
// Shared types and constants of the keyframe interpolator.
// No dependencies; imported by all kli modules.
package kli_pkg;

  localparam int VAL_W     = 16;
  localparam int DUR_W     = 20;
  localparam int TIME_W    = 24;
  localparam int CNT_W     = 16;
  localparam int PROD_W    = TIME_W + VAL_W + 2;
  localparam int DIVD_W    = TIME_W + VAL_W;
  localparam int DIV_CNT_W = $clog2(DIVD_W);
  localparam int STEP_W    = 17;

  // 65536 in Q8.16 is one unit of normalized time
  localparam logic [DIVD_W-1:0] TIME_ONE = DIVD_W'(65536);

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_INITIAL_VALUE = 1'b0,
    CFG_OUTPUT_COUNT  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    DIV_INTERP = 1'b0,
    DIV_STEP   = 1'b1
  } div_sel_t;

  typedef enum logic [1:0] {
    VAL_PREV   = 2'd0,
    VAL_TGT    = 2'd1,
    VAL_INTERP = 2'd2
  } val_sel_t;

  typedef struct packed {
    logic     restart;
    logic     append;
    logic     rd_seg;
    logic     skip;
    logic     mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     val_load;
    val_sel_t val_sel;
    logic     out_load;
    logic     out_ovr;
    logic     step_update;
    logic     step_from_div;
  } kli_cmd_t;

  typedef struct packed {
    logic ovr;
    logic seg_avail;
    logic can_append;
    logic seg_done;
    logic dur_zero;
    logic t_before;
    logic div_busy;
    logic div_done;
    logic step_zero;
    logic out_free;
  } kli_stat_t;

endpackage

FILE: rtl/keyframe_linear_interpolator.sv
// A sample request walks past finished segments through the frame store (S_RD and
// S_CHK for each segment skipped); a bit-serial divider runs at most once for the
// interpolation quotient and at most once for the time step. Clear, append and
// ignored requests finish in S_IDLE. One request is in flight at a time.
// Synchronous reset: no frames, time and sample count 0, output_count 2.
module keyframe_linear_interpolator #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 kind,
  input  logic [kli_pkg::VAL_W-1:0]  new_value,
  input  logic [kli_pkg::DUR_W-1:0]  new_duration,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kli_pkg::VAL_W-1:0]  sample_value,
  output logic [kli_pkg::CNT_W-1:0]  sample_index,
  output logic                       is_final,
  output logic                       overrun,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [15:0]                cfg_data
);
  import kli_pkg::*;

  kli_cmd_t  cmd;
  kli_stat_t stat;

  assign cfg_ready = 1'b1;

  kli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .cmd      (cmd),
    .stat     (stat)
  );

  kli_dp #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .new_value    (new_value),
    .new_duration (new_duration),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .sample_index (sample_index),
    .is_final     (is_final),
    .overrun      (overrun)
  );

endmodule

FILE: rtl/kli_div.sv
// Restoring divider, one quotient bit per cycle, with remainder-nonzero flag.
// Depends on kli_pkg.
module kli_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kli_pkg::DIVD_W-1:0]  dividend,
  input  logic [kli_pkg::DUR_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [kli_pkg::DIVD_W-1:0]  quot,
  output logic                        rem_nz
);
  import kli_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DUR_W-1:0]     rem;
  logic [DIVD_W-1:0]    quo;
  logic [DUR_W-1:0]     dsr;
  logic [DUR_W:0]       shifted;
  logic [DUR_W:0]       trial;
  logic                 fits;

  always_comb begin
    shifted = {rem, quo[DIVD_W-1]};
    trial   = shifted - {1'b0, dsr};
    fits    = ~trial[DUR_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(DIVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      cnt <= cnt + DIV_CNT_W'(1);
      rem <= fits ? trial[DUR_W-1:0] : shifted[DUR_W-1:0];
      quo <= {quo[DIVD_W-2:0], fits};
    end
  end

  assign quot   = quo;
  assign rem_nz = |rem;

endmodule

FILE: rtl/kli_dp.sv
// Datapath: config registers, keyframe store, segment walk, interpolation and output register.
// Depends on kli_pkg, kli_div and the assertion header.
`include "keyframe_linear_interpolator_assert.svh"
module kli_dp #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  kli_pkg::kli_cmd_t          cmd,
  output kli_pkg::kli_stat_t         stat,
  input  logic                       cfg_valid,
  input  logic                       cfg_index,
  input  logic [15:0]                cfg_data,
  input  logic [kli_pkg::VAL_W-1:0]  new_value,
  input  logic [kli_pkg::DUR_W-1:0]  new_duration,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [kli_pkg::VAL_W-1:0]  sample_value,
  output logic [kli_pkg::CNT_W-1:0]  sample_index,
  output logic                       is_final,
  output logic                       overrun
);
  import kli_pkg::*;

  localparam int CW = $clog2(MAX_FRAMES + 1);
  localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

  logic [VAL_W-1:0]  initial_value;
  logic [CNT_W-1:0]  output_count;

  logic [VAL_W-1:0]  mem_tgt [MAX_FRAMES];
  logic [DUR_W-1:0]  mem_dur [MAX_FRAMES];

  logic [CW-1:0]     loaded;
  logic [CW-1:0]     ptr;
  logic [TIME_W-1:0] start_time;
  logic [VAL_W-1:0]  prev;
  logic [TIME_W-1:0] cur_time;
  logic [CNT_W-1:0]  samples;

  logic [VAL_W-1:0]        rd_tgt;
  logic [DUR_W-1:0]        rd_dur;
  logic signed [PROD_W-1:0] prod;
  logic [VAL_W-1:0]        value;

  logic [TIME_W:0]          seg_end;
  logic [TIME_W-1:0]        diff_t;
  logic signed [VAL_W:0]    delta;
  logic signed [PROD_W-1:0] mul_res;
  logic [PROD_W-1:0]        prod_mag;
  logic [DIVD_W-1:0]        div_dividend;
  logic [DUR_W-1:0]         div_divisor;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [DIVD_W-1:0]        div_quot;
  logic                     div_rem_nz;
  logic [DIVD_W:0]          neg_mag;
  logic [DIVD_W:0]          pos_sum;
  logic [VAL_W-1:0]         interp_val;
  logic [VAL_W-1:0]         value_next;
  logic [STEP_W-1:0]        step;
  logic [CNT_W:0]           samples_inc;

  // segment arithmetic
  always_comb begin
    seg_end = {1'b0, start_time} + {{(TIME_W - DUR_W + 1){1'b0}}, rd_dur};
    diff_t  = cur_time - start_time;
    delta   = $signed({1'b0, rd_tgt}) - $signed({1'b0, prev});
    mul_res = $signed({1'b0, diff_t}) * delta;
    prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  end

  always_comb begin
    div_start = cmd.div_start;
    case (cmd.div_sel)
      DIV_INTERP: begin
        div_dividend = prod_mag[DIVD_W-1:0];
        div_divisor  = rd_dur;
      end
      DIV_STEP: begin
        div_dividend = TIME_ONE;
        div_divisor  = DUR_W'(output_count - CNT_W'(1));
      end
      default: begin
        div_dividend = prod_mag[DIVD_W-1:0];
        div_divisor  = rd_dur;
      end
    endcase
  end

  kli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  // floor rounding: a negative quotient rounds away from zero when inexact
  always_comb begin
    neg_mag = {1'b0, div_quot} + (DIVD_W + 1)'(div_rem_nz);
    pos_sum = {{(DIVD_W - VAL_W + 1){1'b0}}, prev} + {1'b0, div_quot};
    if (prod[PROD_W-1]) begin
      if (neg_mag > {{(DIVD_W - VAL_W + 1){1'b0}}, prev}) begin
        interp_val = '0;
      end else begin
        interp_val = prev - neg_mag[VAL_W-1:0];
      end
    end else if (|pos_sum[DIVD_W:VAL_W]) begin
      interp_val = {VAL_W{1'b1}};
    end else begin
      interp_val = pos_sum[VAL_W-1:0];
    end
  end

  always_comb begin
    case (cmd.val_sel)
      VAL_PREV:   value_next = prev;
      VAL_TGT:    value_next = rd_tgt;
      VAL_INTERP: value_next = interp_val;
      default:    value_next = prev;
    endcase
    step        = cmd.step_from_div ? div_quot[STEP_W-1:0] : '0;
    samples_inc = {1'b0, samples} + (CNT_W + 1)'(1);
  end

  always_comb begin
    stat.ovr        = samples >= output_count;
    stat.seg_avail  = ptr < loaded;
    stat.can_append = loaded < CW'(MAX_FRAMES);
    stat.seg_done   = seg_end <= {1'b0, cur_time};
    stat.dur_zero   = rd_dur == '0;
    stat.t_before   = cur_time < start_time;
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
    stat.step_zero  = output_count <= CNT_W'(1);
    stat.out_free   = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_value <= '0;
      output_count  <= CNT_W'(2);
      loaded        <= '0;
      ptr           <= '0;
      start_time    <= '0;
      prev          <= '0;
      cur_time      <= '0;
      samples       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          CFG_INITIAL_VALUE: initial_value <= cfg_data;
          CFG_OUTPUT_COUNT:  output_count  <= cfg_data;
          default:           initial_value <= initial_value;
        endcase
      end
      if (cmd.restart) begin
        loaded     <= '0;
        ptr        <= '0;
        start_time <= '0;
        prev       <= initial_value;
        cur_time   <= '0;
        samples    <= '0;
      end
      if (cmd.append) begin
        loaded <= loaded + CW'(1);
      end
      if (cmd.skip) begin
        start_time <= seg_end[TIME_W-1:0];
        prev       <= rd_tgt;
        ptr        <= ptr + CW'(1);
      end
      if (cmd.step_update) begin
        cur_time <= cur_time + TIME_W'(step);
        samples  <= samples_inc[CNT_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem_tgt[loaded[AW-1:0]] <= new_value;
      mem_dur[loaded[AW-1:0]] <= new_duration;
    end
    if (cmd.rd_seg) begin
      rd_tgt <= mem_tgt[ptr[AW-1:0]];
      rd_dur <= mem_dur[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= mul_res;
    end
    if (cmd.val_load) begin
      value <= value_next;
    end
    if (cmd.out_load) begin
      sample_value <= cmd.out_ovr ? '0 : value;
      sample_index <= samples;
      is_final     <= !cmd.out_ovr && (samples_inc == {1'b0, output_count});
      overrun      <= cmd.out_ovr;
    end
  end

  `KLI_ASSERT(a_loaded_max, loaded <= CW'(MAX_FRAMES))
  `KLI_ASSERT(a_ptr_in_range, ptr <= loaded)
  `KLI_ASSERT_NEXT(a_skip_advances, cmd.skip && !cmd.restart, ptr == $past(ptr) + CW'(1))

endmodule

FILE: rtl/kli_ctrl.sv
// Controller: sequences request decode, segment skip, multiply, divides and output.
// Depends on kli_pkg and the assertion header.
`include "keyframe_linear_interpolator_assert.svh"
module kli_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  output kli_pkg::kli_cmd_t  cmd,
  input  kli_pkg::kli_stat_t stat
);
  import kli_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_MUL,
    S_DIV,
    S_EMIT,
    S_STEP,
    S_STEPW
  } state_t;

  state_t state;
  state_t state_next;
  logic   ovr_req;
  logic   ovr_req_next;
  logic   accept;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    ovr_req_next = ovr_req;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(kind))
            KIND_CLEAR:  cmd.restart = 1'b1;
            KIND_APPEND: cmd.append  = stat.can_append;
            KIND_SAMPLE: begin
              ovr_req_next = stat.ovr;
              state_next   = stat.ovr ? S_EMIT : S_RD;
            end
            KIND_NOP:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (stat.seg_avail) begin
          cmd.rd_seg = 1'b1;
          state_next = S_CHK;
        end else begin
          cmd.val_load = 1'b1;
          cmd.val_sel  = VAL_PREV;
          state_next   = S_EMIT;
        end
      end
      S_CHK: begin
        if (stat.seg_done) begin
          cmd.skip   = 1'b1;
          state_next = S_RD;
        end else if (stat.dur_zero) begin
          cmd.val_load = 1'b1;
          cmd.val_sel  = VAL_TGT;
          state_next   = S_EMIT;
        end else if (stat.t_before) begin
          cmd.val_load = 1'b1;
          cmd.val_sel  = VAL_PREV;
          state_next   = S_EMIT;
        end else begin
          cmd.mul    = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_INTERP;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_sel = DIV_INTERP;
        if (stat.div_done) begin
          cmd.val_load = 1'b1;
          cmd.val_sel  = VAL_INTERP;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ovr  = ovr_req;
          state_next   = ovr_req ? S_IDLE : S_STEP;
        end
      end
      S_STEP: begin
        cmd.div_sel = DIV_STEP;
        if (stat.step_zero) begin
          cmd.step_update = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_STEPW;
        end
      end
      S_STEPW: begin
        cmd.div_sel = DIV_STEP;
        if (stat.div_done) begin
          cmd.step_update   = 1'b1;
          cmd.step_from_div = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ovr_req <= 1'b0;
    end else begin
      state   <= state_next;
      ovr_req <= ovr_req_next;
    end
  end

  `KLI_ASSERT_IMP(a_div_idle_on_start, cmd.div_start, !stat.div_busy)
  `KLI_ASSERT_IMP(a_out_slot_free, cmd.out_load, stat.out_free)
  `KLI_ASSERT_IMP(a_read_in_range, cmd.rd_seg, stat.seg_avail)

endmodule

FILE: tb/sv/keyframe_linear_interpolator_tb.sv
// Self-checking bench for keyframe_linear_interpolator: a bursty driver feeds
// clear/append/sample requests, a curve predictor tracks frames and sweep time.
// Depends on kli_pkg and the keyframe_linear_interpolator RTL.
module keyframe_linear_interpolator_tb;
  import kli_pkg::*;

  localparam int NUM_FRAMES     = 16;
  localparam int HALF_PERIOD    = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 150;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int RANDOM_REQS    = 400;

  typedef struct packed {
    kind_t             kind;
    logic [VAL_W-1:0]  value;
    logic [DUR_W-1:0]  dur;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  index;
    logic              fin;
    logic              ovr;
  } sample_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        kind = KIND_NOP;
  logic [VAL_W-1:0]  new_value = '0;
  logic [DUR_W-1:0]  new_duration = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VAL_W-1:0]  sample_value;
  logic [CNT_W-1:0]  sample_index;
  logic              is_final;
  logic              overrun;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_INITIAL_VALUE;
  logic [15:0]       cfg_data = '0;

  // curve predictor state
  logic [VAL_W-1:0]  frame_tgt [NUM_FRAMES];
  logic [DUR_W-1:0]  frame_dur [NUM_FRAMES];
  int                n_frames;
  int                seg_ptr;
  logic [TIME_W-1:0] seg_start;
  logic [TIME_W-1:0] cur_time;
  logic [VAL_W-1:0]  prev_val;
  logic [VAL_W-1:0]  init_val_q;
  int unsigned       n_emitted;
  int unsigned       out_count_q;

  req_t              pending_reqs[$];
  sample_t           expected_samples[$];

  int burst_left = 0;
  int gap_left = 0;
  int n_queued = 0;
  int n_reqs = 0;
  int n_samples = 0;
  int n_overruns = 0;
  int n_finals = 0;
  int n_cfg_writes = 0;
  int n_errors = 0;

  logic [31:0] ready_pat = '0;
  logic [5:0]  ready_age = '0;

  keyframe_linear_interpolator #(.MAX_FRAMES(NUM_FRAMES)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .new_value    (new_value),
    .new_duration (new_duration),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .sample_index (sample_index),
    .is_final     (is_final),
    .overrun      (overrun),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void restart_curve();
    n_frames = 0;
    seg_ptr = 0;
    seg_start = '0;
    prev_val = init_val_q;
    cur_time = '0;
    n_emitted = 0;
  endfunction

  // skips finished segments, then interpolates inside the current one
  function automatic logic [VAL_W-1:0] curve_value();
    logic [TIME_W:0]   seg_end;
    logic [TIME_W-1:0] t;
    logic              stop;
    longint            num;
    longint            den;
    longint            q;
    t = cur_time;
    stop = 1'b0;
    while (!stop && seg_ptr < n_frames) begin
      seg_end = {1'b0, seg_start} + {5'b0, frame_dur[seg_ptr]};
      if (seg_end > {1'b0, t}) begin
        stop = 1'b1;
      end else begin
        seg_start = seg_end[TIME_W-1:0];
        prev_val = frame_tgt[seg_ptr];
        seg_ptr++;
      end
    end
    if (seg_ptr >= n_frames) return prev_val;
    if (frame_dur[seg_ptr] == '0) return frame_tgt[seg_ptr];
    if (t < seg_start) return prev_val;
    num = longint'(t - seg_start) * (longint'(frame_tgt[seg_ptr]) - longint'(prev_val));
    den = longint'(frame_dur[seg_ptr]);
    if (num >= 0) q = num / den;
    else q = -((-num + den - 1) / den);
    q = q + longint'(prev_val);
    if (q < 0) q = 0;
    if (q > 65535) q = 65535;
    return q[VAL_W-1:0];
  endfunction

  function automatic void track_request(kind_t k, logic [VAL_W-1:0] v, logic [DUR_W-1:0] d);
    sample_t     s;
    int unsigned stride;
    if (k != KIND_NOP) n_reqs++;
    case (k)
      KIND_CLEAR: restart_curve();
      KIND_APPEND: begin
        if (n_frames < NUM_FRAMES) begin
          frame_tgt[n_frames] = v;
          frame_dur[n_frames] = d;
          n_frames++;
        end
      end
      KIND_SAMPLE: begin
        if (n_emitted >= out_count_q) begin
          s.value = '0;
          s.index = CNT_W'(n_emitted);
          s.fin = 1'b0;
          s.ovr = 1'b1;
        end else begin
          s.value = curve_value();
          s.index = CNT_W'(n_emitted);
          s.fin = (n_emitted + 1 == out_count_q);
          s.ovr = 1'b0;
          stride = (out_count_q > 1) ? 65536 / (out_count_q - 1) : 0;
          cur_time = TIME_W'(cur_time + stride);
          n_emitted = (n_emitted + 1) & 32'hFFFF;
        end
        expected_samples.push_back(s);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch %s at %0t: got %0d, want %0d", what, $time, got, want);
  endtask

  // sender: bursts of requests with random gaps
  always @(posedge clk) begin : driver
    req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        track_request(kind_t'(kind), new_value, new_duration);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          kind <= r.kind;
          new_value <= r.value;
          new_duration <= r.dur;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: rotating stall pattern, reloaded when the 6-bit ready_age wraps
  always @(posedge clk) begin : receiver
    logic [31:0] pat;
    if (ready_age == '0)
      pat = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1);
    else
      pat = {ready_pat[0], ready_pat[31:1]};
    ready_pat <= pat;
    out_ready <= pat[0];
    ready_age <= ready_age + 1'b1;
  end

  always @(posedge clk) begin : monitor
    sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("sample with none expected, index", sample_index, 0);
      end else begin
        want = expected_samples.pop_front();
        if (sample_value !== want.value)
          report_mismatch("sample_value", sample_value, want.value);
        if (sample_index !== want.index)
          report_mismatch("sample_index", sample_index, want.index);
        if (is_final !== want.fin)
          report_mismatch("is_final", is_final, want.fin);
        if (overrun !== want.ovr)
          report_mismatch("overrun", overrun, want.ovr);
        n_samples++;
        if (want.ovr) n_overruns++;
        if (want.fin) n_finals++;
      end
    end
  end

  function automatic void add_req(kind_t k, logic [VAL_W-1:0] v, logic [DUR_W-1:0] d);
    req_t r;
    r.kind = k;
    r.value = v;
    r.dur = d;
    pending_reqs.push_back(r);
    if (k != KIND_NOP) n_queued++;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_INITIAL_VALUE) init_val_q = data;
    else out_count_q = data;
    n_cfg_writes++;
    @(posedge clk);
  endtask

  // all requests taken, all samples back and the block idle again
  task automatic wait_idle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_samples.size() != 0 ||
           !in_ready)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_config();
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_INITIAL_VALUE, 16'h0000);
        1:       write_reg(CFG_INITIAL_VALUE, 16'hFFFF);
        default: write_reg(CFG_INITIAL_VALUE, 16'($urandom));
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_OUTPUT_COUNT, 16'd1);
        1:       write_reg(CFG_OUTPUT_COUNT, 16'hFFFF);
        2:       write_reg(CFG_OUTPUT_COUNT, 16'd2);
        3:       write_reg(CFG_OUTPUT_COUNT, 16'($urandom_range(25, 400)));
        default: write_reg(CFG_OUTPUT_COUNT, 16'($urandom_range(3, 16)));
      endcase
    end
  endtask

  // mostly clear, frames, a sweep (full for counts to 24) and stray requests
  task automatic queue_sweep();
    int               nf;
    int               n_samp;
    int               span;
    logic [DUR_W-1:0] d;
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 19))
      0:       nf = 0;
      1, 2:    nf = $urandom_range(17, 19);
      3, 4, 5: nf = $urandom_range(7, 16);
      default: nf = $urandom_range(1, 6);
    endcase
    if ($urandom_range(0, 7) != 0) add_req(KIND_CLEAR, VAL_W'($urandom), DUR_W'($urandom));
    span = 131072 / (nf + 1);
    for (int i = 0; i < nf; i++) begin
      case ($urandom_range(0, 9))
        0:       d = '0;
        1:       d = DUR_W'($urandom);
        2:       d = DUR_W'($urandom_range(1, 16));
        default: d = DUR_W'($urandom_range(1, span));
      endcase
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        default: v = VAL_W'($urandom);
      endcase
      add_req(KIND_APPEND, v, d);
    end
    n_samp = (out_count_q <= 24) ? out_count_q + $urandom_range(0, 2) : $urandom_range(2, 20);
    for (int j = 0; j < n_samp; j++) begin
      case ($urandom_range(0, 15))
        0: add_req(KIND_NOP, VAL_W'($urandom), DUR_W'($urandom));
        1: add_req(KIND_APPEND, VAL_W'($urandom), DUR_W'($urandom_range(1, 65536)));
        2: add_req(kind_t'($urandom_range(0, 3)), VAL_W'($urandom), DUR_W'($urandom));
        default: ;
      endcase
      add_req(KIND_SAMPLE, VAL_W'($urandom), DUR_W'($urandom));
    end
  endtask

  initial begin : stimulus
    init_val_q = '0;
    out_count_q = 2;
    restart_curve();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset registers, no frames: holds the initial value
    add_req(KIND_SAMPLE, '1, '1);
    wait_idle();
    write_reg(CFG_INITIAL_VALUE, 16'hFFFF);
    write_reg(CFG_OUTPUT_COUNT, 16'd5);
    // new initial value not seen until a clear
    add_req(KIND_SAMPLE, '0, '0);
    add_req(KIND_NOP, 16'hA5A5, 20'hFFFFF);
    add_req(KIND_CLEAR, '1, '1);
    add_req(KIND_SAMPLE, '0, '0);
    // frames appended mid-sweep, zero and maximum durations
    add_req(KIND_APPEND, 16'h0000, 20'h04000);
    add_req(KIND_APPEND, 16'hFFFF, 20'h00000);
    add_req(KIND_APPEND, 16'd1000, 20'hFFFFF);
    repeat (4) add_req(KIND_SAMPLE, '0, '0);
    repeat (2) add_req(KIND_SAMPLE, '1, '1);
    wait_idle();
    // single-sample sweep: step of zero
    write_reg(CFG_OUTPUT_COUNT, 16'd1);
    write_reg(CFG_INITIAL_VALUE, 16'h0000);
    add_req(KIND_SAMPLE, '0, '0);
    add_req(KIND_CLEAR, '0, '0);
    add_req(KIND_APPEND, 16'hFFFF, 20'h0FFFF);
    add_req(KIND_SAMPLE, '0, '0);
    add_req(KIND_SAMPLE, '0, '0);
    wait_idle();

    n_queued = 0;
    while (n_queued < RANDOM_REQS) begin
      pick_config();
      repeat ($urandom_range(1, 2)) queue_sweep();
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d requests, %0d register writes", n_reqs, n_cfg_writes);
    $display("checked %0d samples: %0d final, %0d overrun", n_samples, n_finals, n_overruns);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("timed out with %0d samples outstanding", expected_samples.size());
    $display("FAIL");
    $finish;
  end

endmodule
